>>> sv/rhtt_pkg.sv
// shared types and constants for the rectangle hit-test table
package rhtt_pkg;

    localparam int TAG_W  = 32;
    localparam int SLOT_W = 6;
    localparam int CMD_W  = 2;

    // command codes of an input transaction
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // how the pending result is loaded
    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ZERO,
        RES_ADD_OK,
        RES_READ,
        RES_HIT
    } res_sel_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic     load_in;
        logic     clear_count;
        logic     add_entry;
        logic     rd_slot;
        logic     scan_start;
        logic     scan_step;
        res_sel_t res_sel;
        logic     load_out;
    } ctrl_t;

    // status from the datapath to the controller
    typedef struct packed {
        cmd_t cmd;
        logic full;
        logic empty;
        logic slot_ok;
        logic hit;
        logic idx_zero;
        logic out_free;
    } stat_t;

endpackage

>>> sv/rhtt_ctrl.sv
// controller state machine for the rectangle hit-test table
module rhtt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  rhtt_pkg::stat_t stat,
    output rhtt_pkg::ctrl_t ctrl
);

    rhtt_pkg::state_t state_reg;
    rhtt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rhtt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rhtt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rhtt_pkg::ST_EXEC;
                end
            end
            rhtt_pkg::ST_EXEC:
            begin
                case (stat.cmd)
                    rhtt_pkg::CMD_READ:
                    begin
                        state_next = stat.slot_ok ? rhtt_pkg::ST_READ_WAIT
                                                  : rhtt_pkg::ST_FINISH;
                    end
                    rhtt_pkg::CMD_TEST:
                    begin
                        state_next = stat.empty ? rhtt_pkg::ST_FINISH
                                                : rhtt_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = rhtt_pkg::ST_FINISH;
                    end
                endcase
            end
            rhtt_pkg::ST_READ_WAIT:
            begin
                state_next = rhtt_pkg::ST_FINISH;
            end
            rhtt_pkg::ST_SCAN:
            begin
                if (stat.hit || stat.idx_zero)
                begin
                    state_next = rhtt_pkg::ST_FINISH;
                end
            end
            rhtt_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = rhtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rhtt_pkg::ST_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready         = 1'b0;
        ctrl             = '0;
        ctrl.res_sel     = rhtt_pkg::RES_HOLD;
        case (state_reg)
            rhtt_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.load_in = in_valid;
            end
            rhtt_pkg::ST_EXEC:
            begin
                case (stat.cmd)
                    rhtt_pkg::CMD_CLEAR:
                    begin
                        ctrl.clear_count = 1'b1;
                        ctrl.res_sel     = rhtt_pkg::RES_ZERO;
                    end
                    rhtt_pkg::CMD_ADD:
                    begin
                        if (!stat.full)
                        begin
                            ctrl.add_entry = 1'b1;
                            ctrl.res_sel   = rhtt_pkg::RES_ADD_OK;
                        end
                        else
                        begin
                            ctrl.res_sel = rhtt_pkg::RES_ZERO;
                        end
                    end
                    rhtt_pkg::CMD_READ:
                    begin
                        if (stat.slot_ok)
                        begin
                            ctrl.rd_slot = 1'b1;
                        end
                        else
                        begin
                            ctrl.res_sel = rhtt_pkg::RES_ZERO;
                        end
                    end
                    rhtt_pkg::CMD_TEST:
                    begin
                        if (!stat.empty)
                        begin
                            ctrl.scan_start = 1'b1;
                        end
                        else
                        begin
                            ctrl.res_sel = rhtt_pkg::RES_ZERO;
                        end
                    end
                    default:
                    begin
                        ctrl.res_sel = rhtt_pkg::RES_ZERO;
                    end
                endcase
            end
            rhtt_pkg::ST_READ_WAIT:
            begin
                ctrl.res_sel = rhtt_pkg::RES_READ;
            end
            rhtt_pkg::ST_SCAN:
            begin
                if (stat.hit)
                begin
                    ctrl.res_sel = rhtt_pkg::RES_HIT;
                end
                else if (stat.idx_zero)
                begin
                    ctrl.res_sel = rhtt_pkg::RES_ZERO;
                end
                else
                begin
                    ctrl.scan_step = 1'b1;
                end
            end
            rhtt_pkg::ST_FINISH:
            begin
                ctrl.load_out = stat.out_free;
            end
            default:
            begin
                ctrl.res_sel = rhtt_pkg::RES_HOLD;
            end
        endcase
    end

endmodule

>>> sv/rhtt_datapath.sv
// datapath of the rectangle hit-test table: entry memory, count, scan index, result
module rhtt_datapath #(
    parameter int MAX_REGIONS = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rhtt_pkg::ctrl_t                   ctrl,
    output rhtt_pkg::stat_t                   stat,
    input  logic [rhtt_pkg::CMD_W-1:0]        command,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic signed [COORD_BITS-1:0]      size_w,
    input  logic signed [COORD_BITS-1:0]      size_h,
    input  logic [rhtt_pkg::TAG_W-1:0]        tag,
    input  logic [rhtt_pkg::SLOT_W-1:0]       slot,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic signed [COORD_BITS-1:0]      out_w,
    output logic signed [COORD_BITS-1:0]      out_h,
    output logic [rhtt_pkg::TAG_W-1:0]        out_tag
);

    localparam int IDX_W  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W  = $clog2(MAX_REGIONS + 1);
    localparam int CMP_W  = (CNT_W > rhtt_pkg::SLOT_W) ? CNT_W : rhtt_pkg::SLOT_W;
    localparam int WORD_W = 4 * COORD_BITS + rhtt_pkg::TAG_W;
    localparam int X_LO   = 0;
    localparam int Y_LO   = COORD_BITS;
    localparam int W_LO   = 2 * COORD_BITS;
    localparam int H_LO   = 3 * COORD_BITS;
    localparam int T_LO   = 4 * COORD_BITS;

    // captured transaction
    rhtt_pkg::cmd_t                  cmd_reg;
    logic signed [COORD_BITS-1:0]    px_reg;
    logic signed [COORD_BITS-1:0]    py_reg;
    logic signed [COORD_BITS-1:0]    pw_reg;
    logic signed [COORD_BITS-1:0]    ph_reg;
    logic [rhtt_pkg::TAG_W-1:0]      tag_reg;
    logic [rhtt_pkg::SLOT_W-1:0]     slot_reg;

    logic [CNT_W-1:0]                entry_count_reg;
    logic [IDX_W-1:0]                idx_reg;
    logic [IDX_W-1:0]                idx_next;

    logic [WORD_W-1:0]               mem [MAX_REGIONS];
    logic [WORD_W-1:0]               rd_data_reg;
    logic [IDX_W-1:0]                rd_addr;
    logic                            rd_en;

    // pending result
    logic                            res_ok_reg;
    logic signed [COORD_BITS-1:0]    res_x_reg;
    logic signed [COORD_BITS-1:0]    res_y_reg;
    logic signed [COORD_BITS-1:0]    res_w_reg;
    logic signed [COORD_BITS-1:0]    res_h_reg;
    logic [rhtt_pkg::TAG_W-1:0]      res_tag_reg;

    // output register
    logic                            out_valid_reg;
    logic                            ok_reg;
    logic signed [COORD_BITS-1:0]    out_x_reg;
    logic signed [COORD_BITS-1:0]    out_y_reg;
    logic signed [COORD_BITS-1:0]    out_w_reg;
    logic signed [COORD_BITS-1:0]    out_h_reg;
    logic [rhtt_pkg::TAG_W-1:0]      out_tag_reg;

    logic [CNT_W-1:0]                count_m1;
    logic [CMP_W-1:0]                slot_ext;
    logic signed [COORD_BITS-1:0]    rd_x;
    logic signed [COORD_BITS-1:0]    rd_y;
    logic signed [COORD_BITS-1:0]    rd_w;
    logic signed [COORD_BITS-1:0]    rd_h;
    logic [rhtt_pkg::TAG_W-1:0]      rd_tag;
    logic signed [COORD_BITS:0]      px_ext;
    logic signed [COORD_BITS:0]      py_ext;
    logic signed [COORD_BITS:0]      rx_ext;
    logic signed [COORD_BITS:0]      ry_ext;
    logic signed [COORD_BITS:0]      right_edge;
    logic signed [COORD_BITS:0]      bottom_edge;
    logic                            hit;

    // capture the accepted transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg  <= rhtt_pkg::cmd_t'(command);
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pw_reg   <= size_w;
            ph_reg   <= size_h;
            tag_reg  <= tag;
            slot_reg <= slot;
        end
    end

    // entry count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (ctrl.clear_count)
        begin
            entry_count_reg <= '0;
        end
        else if (ctrl.add_entry)
        begin
            entry_count_reg <= entry_count_reg + CNT_W'(1);
        end
    end

    // scan index walks from the newest entry down
    assign count_m1 = entry_count_reg - CNT_W'(1);
    assign slot_ext = CMP_W'(slot_reg);

    always_comb
    begin
        idx_next = idx_reg;
        rd_addr  = idx_reg;
        if (ctrl.rd_slot)
        begin
            rd_addr = slot_ext[IDX_W-1:0];
        end
        else if (ctrl.scan_start)
        begin
            idx_next = count_m1[IDX_W-1:0];
            rd_addr  = count_m1[IDX_W-1:0];
        end
        else if (ctrl.scan_step)
        begin
            idx_next = idx_reg - IDX_W'(1);
            rd_addr  = idx_reg - IDX_W'(1);
        end
    end

    assign rd_en = ctrl.rd_slot | ctrl.scan_start | ctrl.scan_step;

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (ctrl.add_entry)
        begin
            mem[entry_count_reg[IDX_W-1:0]] <= {tag_reg, ph_reg, pw_reg, py_reg, px_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // unpack the read entry
    assign rd_x   = $signed(rd_data_reg[X_LO +: COORD_BITS]);
    assign rd_y   = $signed(rd_data_reg[Y_LO +: COORD_BITS]);
    assign rd_w   = $signed(rd_data_reg[W_LO +: COORD_BITS]);
    assign rd_h   = $signed(rd_data_reg[H_LO +: COORD_BITS]);
    assign rd_tag = rd_data_reg[T_LO +: rhtt_pkg::TAG_W];

    // half-open containment test, edges one bit wider
    assign px_ext      = $signed({px_reg[COORD_BITS-1], px_reg});
    assign py_ext      = $signed({py_reg[COORD_BITS-1], py_reg});
    assign rx_ext      = $signed({rd_x[COORD_BITS-1], rd_x});
    assign ry_ext      = $signed({rd_y[COORD_BITS-1], rd_y});
    assign right_edge  = rx_ext + $signed({rd_w[COORD_BITS-1], rd_w});
    assign bottom_edge = ry_ext + $signed({rd_h[COORD_BITS-1], rd_h});
    assign hit = (px_ext >= rx_ext) && (px_ext < right_edge)
              && (py_ext >= ry_ext) && (py_ext < bottom_edge);

    // pending result
    always_ff @(posedge clk)
    begin
        case (ctrl.res_sel)
            rhtt_pkg::RES_ZERO:
            begin
                res_ok_reg  <= 1'b0;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_w_reg   <= '0;
                res_h_reg   <= '0;
                res_tag_reg <= '0;
            end
            rhtt_pkg::RES_ADD_OK:
            begin
                res_ok_reg  <= 1'b1;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_w_reg   <= '0;
                res_h_reg   <= '0;
                res_tag_reg <= '0;
            end
            rhtt_pkg::RES_READ:
            begin
                res_ok_reg  <= 1'b1;
                res_x_reg   <= rd_x;
                res_y_reg   <= rd_y;
                res_w_reg   <= rd_w;
                res_h_reg   <= rd_h;
                res_tag_reg <= rd_tag;
            end
            rhtt_pkg::RES_HIT:
            begin
                res_ok_reg  <= 1'b1;
                res_x_reg   <= '0;
                res_y_reg   <= '0;
                res_w_reg   <= '0;
                res_h_reg   <= '0;
                res_tag_reg <= rd_tag;
            end
            default:
            begin
                res_ok_reg  <= res_ok_reg;
            end
        endcase
    end

    // output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            ok_reg      <= res_ok_reg;
            out_x_reg   <= res_x_reg;
            out_y_reg   <= res_y_reg;
            out_w_reg   <= res_w_reg;
            out_h_reg   <= res_h_reg;
            out_tag_reg <= res_tag_reg;
        end
    end

    // status to the controller
    assign stat.cmd      = cmd_reg;
    assign stat.full     = (entry_count_reg == CNT_W'(MAX_REGIONS));
    assign stat.empty    = (entry_count_reg == '0);
    assign stat.slot_ok  = (slot_ext < CMP_W'(entry_count_reg));
    assign stat.hit      = hit;
    assign stat.idx_zero = (idx_reg == '0);
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_w     = out_w_reg;
    assign out_h     = out_h_reg;
    assign out_tag   = out_tag_reg;

endmodule

>>> sv/rectangle_hit_test_table.sv
// top level of the rectangle hit-test table
// Usage: a command transaction enters on in_valid/in_ready with command, pos_x,
// pos_y, size_w, size_h, tag and slot; each command returns exactly one result
// transaction on out_valid/out_ready with ok, out_x, out_y, out_w, out_h, out_tag.
// Commands: clear empties the table, add appends a rectangle (ok 0 when full),
// read returns entry slot (ok 0 at or past the count), test returns the tag of the
// newest rectangle whose half-open box holds the point.
// One command is worked at a time. For test the scan reads one entry per cycle
// from the single read port of the entry memory, newest first, up to MAX_REGIONS
// entries, and stops at the first hit.
// in_ready is high only while the controller waits for a command and returns the
// cycle after the result is loaded into the output register.
// A finished result sits in an output register, and if the receiver stalls the
// block holds the next result until that register is taken.
// Reset clears the entry count and the output valid flag; the entry memory is
// not cleared, as only entries below the count are ever read.
module rectangle_hit_test_table #(
    parameter int MAX_REGIONS = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rhtt_pkg::CMD_W-1:0]        command,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic signed [COORD_BITS-1:0]      size_w,
    input  logic signed [COORD_BITS-1:0]      size_h,
    input  logic [rhtt_pkg::TAG_W-1:0]        tag,
    input  logic [rhtt_pkg::SLOT_W-1:0]       slot,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [COORD_BITS-1:0]      out_x,
    output logic signed [COORD_BITS-1:0]      out_y,
    output logic signed [COORD_BITS-1:0]      out_w,
    output logic signed [COORD_BITS-1:0]      out_h,
    output logic [rhtt_pkg::TAG_W-1:0]        out_tag
);

    rhtt_pkg::ctrl_t ctrl;
    rhtt_pkg::stat_t stat;

    // sequencing
    rhtt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // storage, compare and result registers
    rhtt_datapath #(
        .MAX_REGIONS (MAX_REGIONS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .command   (command),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .size_w    (size_w),
        .size_h    (size_h),
        .tag       (tag),
        .slot      (slot),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_w     (out_w),
        .out_h     (out_h),
        .out_tag   (out_tag)
    );

endmodule
